// ===== rtl/core/irpsc_pkg.sv =====
// shared constants, request and response types of the interrupt router
package irpsc_pkg;

  localparam int unsigned NumSources = 32;
  localparam int unsigned NumLines   = 8;
  localparam int unsigned SrcW       = $clog2(NumSources);
  localparam int unsigned LineW      = $clog2(NumLines);
  localparam int unsigned TagW       = 8;

  localparam logic [2:0] OpWriteEntry   = 3'd0;
  localparam logic [2:0] OpReadEntry    = 3'd1;
  localparam logic [2:0] OpSetPending   = 3'd2;
  localparam logic [2:0] OpClearPending = 3'd3;
  localparam logic [2:0] OpReadStatus   = 3'd4;

  typedef struct packed {
    logic                  enable;
    logic [LineW-1:0]      line;
    logic [TagW-1:0]       tag;
  } route_entry_t;

  typedef route_entry_t [NumSources-1:0] route_table_t;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [SrcW-1:0]       source;
    logic                  enable_bit;
    logic [LineW-1:0]      target_line;
    logic [TagW-1:0]       thread_tag;
    logic [NumSources-1:0] bit_mask;
  } irpsc_req_t;

  typedef struct packed {
    logic                  entry_enable;
    logic [LineW-1:0]      entry_line;
    logic [TagW-1:0]       entry_thread;
    logic [NumSources-1:0] pending_bits;
    logic [NumLines-1:0]   line_requests;
  } irpsc_rsp_t;

endpackage

// ===== rtl/core/irpsc_line_req.sv =====
// line request reduction over all route entries and pending bits
module irpsc_line_req
  import irpsc_pkg::*;
(
  input  route_table_t          table_i,
  input  logic [NumSources-1:0] pending_i,
  output logic [NumLines-1:0]   line_req_o
);

  always_comb begin
    line_req_o = '0;
    for (int unsigned i = 0; i < NumSources; i++) begin
      if (pending_i[i] && table_i[i].enable &&
          (32'(table_i[i].line) < NumLines)) begin
        line_req_o[table_i[i].line] = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/interrupt_router_pending_set_clear_top.sv =====
// top level of the interrupt router: route table, pending bits, bus access
//
// usage
//   a bus request (req_i) is taken at a rising edge with start high and
//   busy low; busy stays low, so a request can be issued every cycle
//   each request is registered, then applied to the route table and the
//   pending vector in the following cycle, which also registers the result
//   the result appears on rsp_o with valid_o high for exactly one cycle;
//   results keep request order
//   throughput is one request per cycle; the line request vector is one
//   parallel reduction over all sources in the apply cycle
//   results carry the addressed entry, the pending vector and the line
//   requests as they stand after the access
//   the receiver cannot stall: each result must be taken in its cycle
//   reset clears the route table, the pending vector and both stages;
//   no request is lost or created by reset release
module interrupt_router_pending_set_clear_top
  import irpsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  irpsc_req_t req_i,
  output logic       valid_o,
  output irpsc_rsp_t rsp_o
);

  logic                  req_v_q;
  irpsc_req_t            req_q;
  route_table_t          table_q, table_d;
  logic [NumSources-1:0] pending_q, pending_d;
  logic [NumLines-1:0]   line_req;
  logic                  rsp_v_q;
  irpsc_rsp_t            rsp_q, rsp_d;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else begin
      req_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // apply the request to the state
  always_comb begin
    table_d   = table_q;
    pending_d = pending_q;
    if (req_v_q) begin
      case (req_q.opcode)
        OpWriteEntry: begin
          table_d[req_q.source].enable = req_q.enable_bit;
          table_d[req_q.source].line   = req_q.target_line;
          table_d[req_q.source].tag    = req_q.thread_tag;
        end
        OpSetPending:   pending_d = pending_q | req_q.bit_mask;
        OpClearPending: pending_d = pending_q & ~req_q.bit_mask;
        default: ;
      endcase
    end
  end

  irpsc_line_req u_line_req (
    .table_i    (table_d),
    .pending_i  (pending_d),
    .line_req_o (line_req)
  );

  always_comb begin
    rsp_d.entry_enable  = table_d[req_q.source].enable;
    rsp_d.entry_line    = table_d[req_q.source].line;
    rsp_d.entry_thread  = table_d[req_q.source].tag;
    rsp_d.pending_bits  = pending_d;
    rsp_d.line_requests = line_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q   <= '0;
      pending_q <= '0;
      rsp_v_q   <= 1'b0;
    end else begin
      table_q   <= table_d;
      pending_q <= pending_d;
      rsp_v_q   <= req_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_v_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_v_q;
  assign rsp_o   = rsp_q;

  // every request gives exactly one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 valid_o)
    else $error("request without result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##2 !valid_o)
    else $error("result without request");

  // a clear leaves no masked bit pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_v_q && (req_q.opcode == OpClearPending)
      |=> (rsp_o.pending_bits & $past(req_q.bit_mask)) == '0)
    else $error("cleared pending bit still set");

  // no line request without a pending source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (rsp_o.pending_bits == '0) |-> rsp_o.line_requests == '0)
    else $error("line request with nothing pending");

endmodule
